/* src/vcse_pkg.sv */
`timescale 1ns / 1ps
package vcse_pkg;

  typedef enum logic [2:0] {
    OP_INIT_THREAD   = 3'd0,
    OP_ACQUIRE       = 3'd1,
    OP_RELEASE       = 3'd2,
    OP_RELEASE_STORE = 3'd3,
    OP_ACQ_REL       = 3'd4,
    OP_SET_ELEMENT   = 3'd5,
    OP_RESET_SYNC    = 3'd6,
    OP_READ          = 3'd7
  } vcse_op_t;

  // Decoded operation, already qualified by the range checks.
  typedef struct packed {
    logic init_en;
    logic acq_en;
    logic rel_en;
    logic rst_en;
    logic ar_en;
    logic set_en;
    logic rd_en;
    logic rd_sync;
    logic rsync_en;
  } vcse_ctrl_t;

endpackage

/* src/vector_clock_sync_engine_core.sv */
`timescale 1ns / 1ps
// Vector clock engine: one clock per thread and one per sync object.
// Command channel: an operation is taken at a clock edge with start high
// and busy low. Every operation then walks all MAX_THREADS clock elements
// through one shared element unit, one element per cycle, with the reads of
// both clock memories registered one element ahead of the writes.
// Busy stays high until the walk is done and the result is issued, so a new
// operation cannot be taken before the last one is through.
// Result channel: out_valid is high for exactly one cycle with out_acquired,
// out_epoch_out and out_status; the receiver cannot stall it.
// Reset: after rst_n rises the block clears both size tables, one entry per
// cycle, with busy high until every entry is cleared. Clock entries at or
// beyond a clock's size read as zero, so the clock memories themselves need
// no clearing.
module vector_clock_sync_engine_core #(
  parameter int MAX_THREADS = 64,
  parameter int NUM_SYNCS   = 256,
  parameter int EPOCH_BITS  = 42
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [5:0]  in_thread,
  input  logic [7:0]  in_sync_id,
  input  logic [5:0]  in_element_index,
  input  logic [41:0] in_new_epoch,
  input  logic        in_from_sync,
  output logic        out_valid,
  output logic        out_acquired,
  output logic [41:0] out_epoch_out,
  output logic        out_status
);
  import vcse_pkg::*;

  localparam int TW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int SIW = (NUM_SYNCS > 1) ? $clog2(NUM_SYNCS) : 1;
  localparam int SZW = $clog2(MAX_THREADS + 1);
  localparam int TD  = 1 << (2 * TW);
  localparam int SD  = 1 << (SIW + TW);
  localparam int CLN = (MAX_THREADS > NUM_SYNCS) ? MAX_THREADS : NUM_SYNCS;
  localparam int CLW = (CLN > 1) ? $clog2(CLN) : 1;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_LOOP, S_DONE} state_t;

  state_t                state_r;
  logic [CLW-1:0]        clr_r;
  logic [SZW-1:0]        i_r;
  logic                  pv_r;
  logic [TW-1:0]         wi_r;
  vcse_ctrl_t            ctrl_r, ctrl_nxt;
  logic [TW-1:0]         t_r, e_r;
  logic [SIW-1:0]        s_r;
  logic [EPOCH_BITS-1:0] v_r;
  logic                  grew_r, status_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic                  ov_r, oacq_r, ost_r;
  logic [41:0]           oep_r;

  logic [EPOCH_BITS-1:0] tmem [TD];
  logic [EPOCH_BITS-1:0] smem [SD];
  logic [SZW-1:0]        tsz_mem [MAX_THREADS];
  logic [SZW-1:0]        ssz_mem [NUM_SYNCS];
  logic [EPOCH_BITS-1:0] tm_q, sm_q;
  logic [SZW-1:0]        ts_q, ss_q;

  logic                  accept, t_ok, s_ok, e_ok;
  vcse_op_t              op;
  logic [SZW-1:0]        ts_a, ts_new, ss_new;
  logic                  t_we, s_we, grew, lt_hit, rd_hit;
  logic [EPOCH_BITS-1:0] t_wd, s_wd, rd_val;
  logic                  sz_we;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = state_r != S_IDLE;
  assign op     = vcse_op_t'(in_operation);
  assign t_ok   = 32'(in_thread) < MAX_THREADS;
  assign s_ok   = 32'(in_sync_id) < NUM_SYNCS;
  assign e_ok   = 32'(in_element_index) < MAX_THREADS;

  always_comb begin
    ctrl_nxt          = '0;
    ctrl_nxt.init_en  = t_ok && op == OP_INIT_THREAD;
    ctrl_nxt.acq_en   = t_ok && s_ok && (op == OP_ACQUIRE || op == OP_ACQ_REL);
    ctrl_nxt.rel_en   = t_ok && s_ok && op == OP_RELEASE;
    ctrl_nxt.rst_en   = t_ok && s_ok && op == OP_RELEASE_STORE;
    ctrl_nxt.ar_en    = t_ok && s_ok && op == OP_ACQ_REL;
    ctrl_nxt.set_en   = t_ok && e_ok && op == OP_SET_ELEMENT;
    ctrl_nxt.rd_en    = t_ok && e_ok && op == OP_READ && (!in_from_sync || s_ok);
    ctrl_nxt.rd_sync  = in_from_sync;
    ctrl_nxt.rsync_en = t_ok && s_ok && op == OP_RESET_SYNC;
  end

  vcse_elem_unit #(
    .MAX_THREADS(MAX_THREADS),
    .EPOCH_BITS (EPOCH_BITS),
    .TW         (TW),
    .SZW        (SZW)
  ) u_elem (
    .ctrl  (ctrl_r),
    .wi    (wi_r),
    .elem  (e_r),
    .ts    (ts_q),
    .ss    (ss_q),
    .tm    (tm_q),
    .sm    (sm_q),
    .val   (v_r),
    .ts_a  (ts_a),
    .t_we  (t_we),
    .t_wd  (t_wd),
    .s_we  (s_we),
    .s_wd  (s_wd),
    .grew  (grew),
    .lt_hit(lt_hit),
    .rd_hit(rd_hit),
    .rd_val(rd_val)
  );

  // Clock element memories: read one element ahead, write the updated one.
  always_ff @(posedge clk) begin
    tm_q <= tmem[{t_r, i_r[TW-1:0]}];
    sm_q <= smem[{s_r, i_r[TW-1:0]}];
    if (state_r == S_LOOP && pv_r && t_we) begin
      tmem[{t_r, wi_r}] <= t_wd;
    end
    if (state_r == S_LOOP && pv_r && s_we) begin
      smem[{s_r, wi_r}] <= s_wd;
    end
  end

  // Final sizes after the walk.
  always_comb begin
    ts_new = ts_q;
    ss_new = ss_q;
    if (ctrl_r.init_en) begin
      ts_new = SZW'(t_r) + SZW'(1);
    end
    if (ctrl_r.acq_en) begin
      ts_new = ts_a;
    end
    if (ctrl_r.rel_en || ctrl_r.rst_en || ctrl_r.ar_en) begin
      ss_new = (ss_q > ts_a) ? ss_q : ts_a;
    end
    if (ctrl_r.set_en && !status_r && ts_q <= SZW'(e_r)) begin
      ts_new = SZW'(e_r) + SZW'(1);
    end
    if (ctrl_r.rsync_en) begin
      ss_new = '0;
    end
  end

  assign sz_we = state_r == S_DONE;

  always_ff @(posedge clk) begin
    if (accept) begin
      ts_q <= tsz_mem[TW'(in_thread)];
      ss_q <= ssz_mem[SIW'(in_sync_id)];
    end
    if (state_r == S_CLR) begin
      if (32'(clr_r) < MAX_THREADS) begin
        tsz_mem[clr_r[TW-1:0]] <= '0;
      end
      if (32'(clr_r) < NUM_SYNCS) begin
        ssz_mem[clr_r[SIW-1:0]] <= '0;
      end
    end else if (sz_we) begin
      tsz_mem[t_r] <= ts_new;
      if (ctrl_r.rel_en || ctrl_r.rst_en || ctrl_r.ar_en || ctrl_r.rsync_en) begin
        ssz_mem[s_r] <= ss_new;
      end
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      i_r     <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      ctrl_r  <= '0;
    end else begin
      ov_r <= state_r == S_DONE;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CLW'(1);
          if (32'(clr_r) == CLN - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ctrl_r   <= ctrl_nxt;
            t_r      <= TW'(in_thread);
            s_r      <= SIW'(in_sync_id);
            e_r      <= TW'(in_element_index);
            v_r      <= EPOCH_BITS'(in_new_epoch);
            i_r      <= '0;
            pv_r     <= 1'b0;
            grew_r   <= 1'b0;
            status_r <= 1'b0;
            epoch_r  <= '0;
            state_r  <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (pv_r) begin
            grew_r   <= grew_r | grew;
            status_r <= status_r | lt_hit;
            if (rd_hit) begin
              epoch_r <= rd_val;
            end
          end
          wi_r <= i_r[TW-1:0];
          if (32'(i_r) == MAX_THREADS) begin
            pv_r    <= 1'b0;
            state_r <= S_DONE;
          end else begin
            pv_r <= 1'b1;
            i_r  <= i_r + SZW'(1);
          end
        end
        S_DONE: begin
          oacq_r  <= grew_r;
          ost_r   <= status_r;
          oep_r   <= 42'(epoch_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  assign out_valid     = ov_r;
  assign out_acquired  = oacq_r;
  assign out_status    = ost_r;
  assign out_epoch_out = oep_r;

endmodule

/* src/vcse_elem_unit.sv */
`timescale 1ns / 1ps
module vcse_elem_unit #(
  parameter int MAX_THREADS = 64,
  parameter int EPOCH_BITS  = 42,
  parameter int TW          = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1,
  parameter int SZW         = $clog2(MAX_THREADS + 1)
) (
  input  vcse_pkg::vcse_ctrl_t  ctrl,
  input  logic [TW-1:0]         wi,
  input  logic [TW-1:0]         elem,
  input  logic [SZW-1:0]        ts,
  input  logic [SZW-1:0]        ss,
  input  logic [EPOCH_BITS-1:0] tm,
  input  logic [EPOCH_BITS-1:0] sm,
  input  logic [EPOCH_BITS-1:0] val,
  output logic [SZW-1:0]        ts_a,
  output logic                  t_we,
  output logic [EPOCH_BITS-1:0] t_wd,
  output logic                  s_we,
  output logic [EPOCH_BITS-1:0] s_wd,
  output logic                  grew,
  output logic                  lt_hit,
  output logic                  rd_hit,
  output logic [EPOCH_BITS-1:0] rd_val
);
  import vcse_pkg::*;

  logic [SZW-1:0]        wix;
  logic                  in_t, in_s, ss_nz, acq_act, hit, store_mode, merge_mode;
  logic [EPOCH_BITS-1:0] te, se, at;
  logic [SZW-1:0]        lim;

  always_comb begin
    wix     = SZW'(wi);
    in_t    = wix < ts;
    in_s    = wix < ss;
    te      = in_t ? tm : '0;
    se      = in_s ? sm : '0;
    ss_nz   = ss != '0;
    acq_act = ctrl.acq_en && ss_nz && in_s;
    grew    = acq_act && (se > te);
    at      = grew ? se : te;
    ts_a    = (ctrl.acq_en && ss_nz && ss > ts) ? ss : ts;
    hit     = wi == elem;

    store_mode = ctrl.rst_en || ctrl.ar_en || (ctrl.rel_en && !ss_nz);
    merge_mode = ctrl.rel_en && ss_nz;
    lim        = (ss > ts_a) ? ss : ts_a;

    s_we = 1'b0;
    s_wd = '0;
    if (store_mode) begin
      s_we = wix < lim;
      s_wd = (wix < ts_a) ? at : '0;
    end else if (merge_mode) begin
      s_we = in_t;
      s_wd = (se > te) ? se : te;
    end

    t_we   = 1'b0;
    t_wd   = '0;
    lt_hit = 1'b0;
    if (ctrl.init_en) begin
      t_we = 1'b1;
    end else if (acq_act) begin
      t_we = 1'b1;
      t_wd = at;
    end else if (ctrl.set_en) begin
      if (hit) begin
        lt_hit = val < te;
        t_we   = !lt_hit;
        t_wd   = val;
      end else if (!in_t) begin
        // zero the gap a growing size would expose
        t_we = 1'b1;
      end
    end

    rd_hit = ctrl.rd_en && hit;
    rd_val = ctrl.rd_sync ? se : te;
  end

endmodule

/* src/vcse_checker.sv */
`timescale 1ns / 1ps
module vcse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_acquired,
  input logic [41:0] out_epoch_out,
  input logic        out_status
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("block not clearing after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_acquired && out_epoch_out == 42'd0)
    else $error("status result carries other fields");

endmodule

bind vector_clock_sync_engine_core vcse_checker u_vcse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_acquired (out_acquired),
  .out_epoch_out(out_epoch_out),
  .out_status   (out_status)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import vcse_pkg::*;

  localparam int NTHR = 64;
  localparam int NSYNC = 256;
  localparam logic [41:0] EPOCH_MAX = 42'h3FF_FFFF_FFFF;

  typedef struct {
    logic        acquired;
    logic [41:0] epoch;
    logic        status;
  } vc_result_t;

  typedef struct {
    vcse_op_t    op;
    logic [5:0]  thr;
    logic [7:0]  sid;
    logic [5:0]  elem;
    logic [41:0] val;
    logic        fsync;
    bit          typed;
    vc_result_t  want;
  } vc_cmd_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [5:0]  in_thread = '0;
  logic [7:0]  in_sync_id = '0;
  logic [5:0]  in_element_index = '0;
  logic [41:0] in_new_epoch = '0;
  logic        in_from_sync = 0;
  logic        out_valid;
  logic        out_acquired;
  logic [41:0] out_epoch_out;
  logic        out_status;

  vector_clock_sync_engine_core DUT (.*);

  always #4 clk = ~clk;

  // Shadow of the clock memories
  logic [41:0] thr_clk [NTHR][NTHR];
  int          thr_size [NTHR];
  logic [41:0] sync_clk [NSYNC][NTHR];
  int          sync_size [NSYNC];

  vc_result_t pending_results[$];
  bit         cur_typed;
  vc_result_t cur_want;
  int         mismatches = 0;
  int         n_checked = 0;
  int         n_grew = 0;
  int         n_stale = 0;

  function automatic bit merge_into_thread(int t, int s);
    bit grew = 0;
    if (sync_size[s] == 0) return 0;
    if (thr_size[t] < sync_size[s]) thr_size[t] = sync_size[s];
    for (int i = 0; i < sync_size[s]; i++)
      if (thr_clk[t][i] < sync_clk[s][i]) begin
        thr_clk[t][i] = sync_clk[s][i];
        grew = 1;
      end
    return grew;
  endfunction

  function automatic void copy_to_sync(int t, int s);
    if (sync_size[s] < thr_size[t]) sync_size[s] = thr_size[t];
    for (int i = 0; i < NTHR; i++)
      if (i < thr_size[t]) sync_clk[s][i] = thr_clk[t][i];
      else if (i < sync_size[s]) sync_clk[s][i] = '0;
  endfunction

  function automatic vc_result_t advance_clocks(vc_cmd_t c);
    vc_result_t r = '{0, '0, 0};
    int t = c.thr;
    int s = c.sid;
    int e = c.elem;
    case (c.op)
      OP_INIT_THREAD: begin
        for (int i = 0; i < NTHR; i++) thr_clk[t][i] = '0;
        thr_size[t] = t + 1;
      end
      OP_ACQUIRE: r.acquired = merge_into_thread(t, s);
      OP_RELEASE: begin
        if (sync_size[s] == 0) copy_to_sync(t, s);
        else begin
          if (sync_size[s] < thr_size[t]) sync_size[s] = thr_size[t];
          for (int i = 0; i < thr_size[t]; i++)
            if (sync_clk[s][i] < thr_clk[t][i]) sync_clk[s][i] = thr_clk[t][i];
        end
      end
      OP_RELEASE_STORE: copy_to_sync(t, s);
      OP_ACQ_REL: begin
        r.acquired = merge_into_thread(t, s);
        copy_to_sync(t, s);
      end
      OP_SET_ELEMENT: begin
        if (c.val < thr_clk[t][e]) r.status = 1;
        else begin
          thr_clk[t][e] = c.val;
          if (thr_size[t] <= e) thr_size[t] = e + 1;
        end
      end
      OP_RESET_SYNC: begin
        for (int i = 0; i < NTHR; i++) sync_clk[s][i] = '0;
        sync_size[s] = 0;
      end
      default: begin
        if (c.fsync) begin
          if (e < sync_size[s]) r.epoch = sync_clk[s][e];
        end else if (e < thr_size[t]) r.epoch = thr_clk[t][e];
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Predict on every transfer, check every strobed result
  always @(posedge clk) begin
    vc_cmd_t    c;
    vc_result_t r;
    vc_result_t w;
    if (rst_n && start && !busy) begin
      c.op = vcse_op_t'(in_operation);
      c.thr = in_thread;
      c.sid = in_sync_id;
      c.elem = in_element_index;
      c.val = in_new_epoch;
      c.fsync = in_from_sync;
      r = advance_clocks(c);
      if (r.acquired) n_grew++;
      if (r.status) n_stale++;
      pending_results.push_back(cur_typed ? cur_want : r);
    end
    if (out_valid) begin
      if (pending_results.size() == 0) flag_mismatch("unexpected result", 1, 0);
      else begin
        w = pending_results.pop_front();
        n_checked++;
        if (out_acquired !== w.acquired) flag_mismatch("acquired", out_acquired, w.acquired);
        if (out_epoch_out !== w.epoch) flag_mismatch("epoch_out", out_epoch_out, w.epoch);
        if (out_status !== w.status) flag_mismatch("status", out_status, w.status);
      end
    end
  end

  vc_cmd_t directed[$];
  int      burst_left = 0;

  function automatic vc_cmd_t mk(vcse_op_t op, int t, int s, int e, logic [41:0] v,
                                 bit fs, bit typed = 0, bit acq = 0,
                                 logic [41:0] ep = '0, bit st = 0);
    vc_cmd_t c;
    c.op = op; c.thr = 6'(t); c.sid = 8'(s); c.elem = 6'(e); c.val = v; c.fsync = fs;
    c.typed = typed;
    c.want = '{acq, ep, st};
    return c;
  endfunction

  // Hold start through busy, then usually open a gap at the end of each burst
  task automatic send(vc_cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 90)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_operation <= c.op;
    in_thread <= c.thr;
    in_sync_id <= c.sid;
    in_element_index <= c.elem;
    in_new_epoch <= c.val;
    in_from_sync <= c.fsync;
    cur_typed <= c.typed;
    cur_want <= c.want;
    do @(posedge clk); while (busy);
  endtask

  function automatic vc_cmd_t random_cmd();
    vc_cmd_t c;
    int t_hi = ($urandom_range(0, 9) == 0) ? 63 : 7;
    int s_hi = ($urandom_range(0, 9) == 0) ? 255 : 5;
    c.op = vcse_op_t'($urandom_range(0, 7));
    if ($urandom_range(0, 15) == 0) c.op = OP_RESET_SYNC;
    c.thr = 6'($urandom_range(0, t_hi));
    c.sid = 8'($urandom_range(0, s_hi));
    c.elem = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8));
    case ($urandom_range(0, 2))
      0: c.val = 42'({$urandom, $urandom});
      1: c.val = 42'($urandom_range(0, 1000));
      default: c.val = 42'(thr_clk[c.thr][c.elem] + 42'($urandom_range(0, 50)));
    endcase
    c.fsync = 1'($urandom_range(0, 1));
    c.typed = 0;
    c.want = '{0, '0, 0};
    return c;
  endfunction

  initial begin
    for (int i = 0; i < NTHR; i++) begin
      thr_size[i] = 0;
      for (int j = 0; j < NTHR; j++) thr_clk[i][j] = '0;
    end
    for (int i = 0; i < NSYNC; i++) begin
      sync_size[i] = 0;
      for (int j = 0; j < NTHR; j++) sync_clk[i][j] = '0;
    end
    cur_typed = 0;
    cur_want = '{0, '0, 0};
    directed.push_back(mk(OP_READ, 5, 0, 0, '0, 0, 1));
    directed.push_back(mk(OP_READ, 0, 255, 63, '0, 1, 1));
    directed.push_back(mk(OP_INIT_THREAD, 63, 0, 0, '0, 0, 1));
    directed.push_back(mk(OP_SET_ELEMENT, 63, 0, 63, EPOCH_MAX, 0, 1));
    directed.push_back(mk(OP_SET_ELEMENT, 63, 0, 63, '0, 0, 1, 0, '0, 1));
    directed.push_back(mk(OP_READ, 63, 0, 63, '0, 0, 1, 0, EPOCH_MAX));
    directed.push_back(mk(OP_RELEASE, 63, 255, 0, '0, 0));
    directed.push_back(mk(OP_ACQUIRE, 0, 255, 0, '0, 0, 1, 1));
    directed.push_back(mk(OP_READ, 0, 255, 63, '0, 1, 1, 0, EPOCH_MAX));
    directed.push_back(mk(OP_SET_ELEMENT, 0, 0, 0, 42'd5, 0));
    directed.push_back(mk(OP_RELEASE, 0, 255, 0, '0, 0));
    directed.push_back(mk(OP_RELEASE_STORE, 0, 0, 0, '0, 0));
    directed.push_back(mk(OP_ACQ_REL, 1, 255, 0, '0, 0));
    directed.push_back(mk(OP_ACQ_REL, 1, 255, 0, '0, 0, 1));
    directed.push_back(mk(OP_RESET_SYNC, 0, 255, 0, '0, 0, 1));
    directed.push_back(mk(OP_ACQUIRE, 2, 255, 0, '0, 0, 1));
    directed.push_back(mk(OP_READ, 2, 255, 0, '0, 1, 1));
    directed.push_back(mk(OP_INIT_THREAD, 3, 0, 0, '0, 0));
    directed.push_back(mk(OP_READ, 3, 0, 40, '0, 0, 1));
    directed.push_back(mk(OP_SET_ELEMENT, 3, 0, 40, 42'h2AA_AAAA_AAAA, 0, 1));
    directed.push_back(mk(OP_RELEASE, 3, 0, 0, '0, 0));
    directed.push_back(mk(OP_READ, 3, 0, 40, '0, 1));

    repeat (7) @(posedge clk);
    rst_n <= 1;
    foreach (directed[i]) send(directed[i]);
    for (int n = 0; n < 1700; n++) begin
      if (n == 800) begin
        start <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      send(random_cmd());
    end
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Checked %0d results over all eight operations; %0d acquires grew a clock,",
             n_checked, n_grew);
    $display("%0d stale element writes were refused.", n_stale);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
src/vcse_pkg.sv
src/vcse_elem_unit.sv
src/vector_clock_sync_engine_core.sv
src/vcse_checker.sv
tb/sv/tb_top.sv
